/* design/murmur3_32_hash_assert.svh */
// Assertion macros for the murmur3_32_hash block.
`ifndef MURMUR3_32_HASH_ASSERT_SVH
`define MURMUR3_32_HASH_ASSERT_SVH

`ifndef SYNTH

// Clocked check, masked while reset is high
`define M3H_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset
`define M3H_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define M3H_ASSERT(lbl, clk, rst, prop, msg)

`define M3H_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* design/m3h_pkg.sv */
// Shared widths and hash constants for the murmur3_32_hash block.
package m3h_pkg;

   localparam int WORD_W = 32;
   localparam int CNT_W  = 3;

   // Scramble and mixing constants
   localparam logic [WORD_W-1:0] C1        = 32'hcc9e2d51;
   localparam logic [WORD_W-1:0] C2        = 32'h1b873593;
   localparam logic [WORD_W-1:0] BLOCK_ADD = 32'he6546b64;
   localparam logic [WORD_W-1:0] FMIX_M1   = 32'h85ebca6b;
   localparam logic [WORD_W-1:0] FMIX_M2   = 32'hc2b2ae35;
   localparam logic [WORD_W-1:0] SEED_RESET = 32'd1234;

   // Byte counts
   localparam logic [CNT_W-1:0] BYTES_FULL = 3'd4;

endpackage

/* design/m3h_mul.sv */
// Shared 32x32 multiplier with a registered low-word product.
module m3h_mul
   import m3h_pkg::*;
(
   input  logic              clock,
   input  logic              mul_en,
   input  logic [WORD_W-1:0] op_a,
   input  logic [WORD_W-1:0] op_b,
   output logic [WORD_W-1:0] prod
);

   logic [2*WORD_W-1:0] full_prod;
   logic [WORD_W-1:0]   prod_ff;
   logic [WORD_W-1:0]   prod_in;

   // Only the low word is kept (arithmetic mod 2^32)
   assign full_prod = op_a * op_b;
   assign prod_in   = full_prod[WORD_W-1:0];

   // Product holds while the unit is not enabled
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

/* design/murmur3_32_hash.sv */
// MurmurHash3 x86_32 over a word stream: input channel (req_), result channel (rsp_),
// seed register (csr_).
//
// Each req_ transfer carries one little-endian word of a message; req_tlast marks the
// final word, whose byte count (0 to 4, above 4 taken as 4) is in req_tuser. Earlier
// words always count as four bytes. The seed is sampled at the first word of a message.
// One rsp_ transfer with the finished hash follows each final word.
//
// Schedule: one shared 32x32 multiplier does both scramble multiplies and both finalizer
// multiplies, in turn. A non-final word passes the steps multiply, multiply, fold. A final
// word with four bytes then goes on to the finalizer; one with one to three bytes skips the
// fold, and an empty one goes straight to the finalizer. req_tready is high only while the
// sequencer is idle; a result waiting in the output register does not block new words.
// If the receiver stalls, the next result waits in the last finalizer step until the
// output register is free.
//
// Reset (synchronous, active high) closes any open message, drops a pending result
// and restores the seed to 1234.
module murmur3_32_hash
   import m3h_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // seed register write
   input  logic              csr_we,
   input  logic [WORD_W-1:0] csr_wdata,
   // input words
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,   // [31:0] data_word
   input  logic [CNT_W-1:0]  req_tuser,   // [2:0] valid_bytes
   input  logic              req_tlast,   // last_item
   // hash results
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [WORD_W-1:0] rsp_tdata    // [31:0] hash_value
);

`include "murmur3_32_hash_assert.svh"

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL2,
      ST_FOLD,
      ST_FIN,
      ST_FM1,
      ST_FM2
   } state_type;

   state_type         state_ff, state_in;
   logic [WORD_W-1:0] seed_ff, seed_in;
   logic [WORD_W-1:0] hash_ff, hash_in;
   logic [WORD_W-1:0] total_ff, total_in;
   logic              in_msg_ff, in_msg_in;
   logic              last_ff, last_in;
   logic              full_ff, full_in;
   logic              tail_ff, tail_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;

   logic              req_xfer;
   logic [CNT_W-1:0]  nbytes_sat;
   logic [WORD_W-1:0] word_masked;
   logic [WORD_W-1:0] total_base;
   logic [WORD_W-1:0] fold_x;
   logic [WORD_W-1:0] fold_r;
   logic [WORD_W-1:0] fin_x;
   logic [WORD_W-1:0] fin_y;
   logic [WORD_W-1:0] fm1_y;
   logic [WORD_W-1:0] fm2_y;
   logic              out_free;

   logic              mul_en;
   logic [WORD_W-1:0] mul_a;
   logic [WORD_W-1:0] mul_b;
   logic [WORD_W-1:0] mul_p;

   // Keep only the valid low bytes of a tail word
   function automatic logic [WORD_W-1:0] tail_mask(input logic [CNT_W-1:0] n);
      logic [WORD_W-1:0] m;
      unique case (n)
         3'd1:    m = 32'h0000_00ff;
         3'd2:    m = 32'h0000_ffff;
         3'd3:    m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

   m3h_mul u_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .prod   (mul_p)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Byte count of this word: non-final words are full, counts above four saturate
   assign nbytes_sat  = (!req_tlast || req_tuser > BYTES_FULL) ? BYTES_FULL : req_tuser;
   assign word_masked = req_tdata & tail_mask(nbytes_sat);
   assign total_base  = in_msg_ff ? total_ff : '0;

   // Block fold: h ^= k; rotl 13; h*5 + constant
   assign fold_x = hash_ff ^ mul_p;
   assign fold_r = {fold_x[WORD_W-14:0], fold_x[WORD_W-1:WORD_W-13]};

   // Finalizer steps around the two multiplies
   assign fin_x = hash_ff ^ (tail_ff ? mul_p : '0) ^ total_ff;
   assign fin_y = fin_x ^ (fin_x >> 16);
   assign fm1_y = mul_p ^ (mul_p >> 13);
   assign fm2_y = mul_p ^ (mul_p >> 16);

   // Multiplier operand select
   always_comb begin
      mul_en = 1'b0;
      mul_a  = word_masked;
      mul_b  = C1;
      unique case (state_ff)
         ST_IDLE: begin
            mul_en = req_xfer;
         end
         ST_MUL2: begin
            mul_en = 1'b1;
            mul_a  = {mul_p[WORD_W-16:0], mul_p[WORD_W-1:WORD_W-15]};
            mul_b  = C2;
         end
         ST_FIN: begin
            mul_en = 1'b1;
            mul_a  = fin_y;
            mul_b  = FMIX_M1;
         end
         ST_FM1: begin
            mul_en = 1'b1;
            mul_a  = fm1_y;
            mul_b  = FMIX_M2;
         end
         ST_FOLD, ST_FM2: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      seed_in      = csr_we ? csr_wdata : seed_ff;
      hash_in      = hash_ff;
      total_in     = total_ff;
      in_msg_in    = in_msg_ff;
      last_in      = last_ff;
      full_in      = full_ff;
      tail_in      = tail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               hash_in   = in_msg_ff ? hash_ff : seed_ff;
               total_in  = total_base + {{(WORD_W-CNT_W){1'b0}}, nbytes_sat};
               in_msg_in = 1'b1;
               last_in   = req_tlast;
               full_in   = (nbytes_sat == BYTES_FULL);
               tail_in   = (nbytes_sat != BYTES_FULL) && (nbytes_sat != '0);
               state_in  = (nbytes_sat != '0) ? ST_MUL2 : ST_FIN;
            end
         end
         ST_MUL2: begin
            state_in = full_ff ? ST_FOLD : ST_FIN;
         end
         ST_FOLD: begin
            hash_in  = (fold_r << 2) + fold_r + BLOCK_ADD;
            state_in = last_ff ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            state_in = ST_FM1;
         end
         ST_FM1: begin
            state_in = ST_FM2;
         end
         ST_FM2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = fm2_y;
               hash_in      = fm2_y;
               in_msg_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= SEED_RESET;
         total_ff     <= '0;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         total_ff     <= total_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hash_ff     <= hash_in;
      last_ff     <= last_in;
      full_ff     <= full_in;
      tail_ff     <= tail_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   `M3H_ASSERT(a_busy_after_xfer, clock, reset, req_xfer |=> !req_tready,
      "block still ready after taking a word")
   `M3H_ASSERT(a_empty_to_fin, clock, reset,
      req_xfer && req_tlast && (req_tuser == '0) |=> (state_ff == ST_FIN),
      "empty final word did not go straight to the finalizer")
   `M3H_ASSERT(a_rsp_from_fm2, clock, reset, $rose(rsp_tvalid) |-> $past(state_ff == ST_FM2),
      "result raised outside the last finalizer step")
   `M3H_ASSERT(a_busy_in_msg, clock, reset, (state_ff != ST_IDLE) |-> in_msg_ff,
      "sequencer busy with no open message")

endmodule

/* verif/murmur3_32_hash_check.sv */
// Scoreboard for murmur3_32_hash: tracks seed writes and word transfers, predicts hashes, checks.
`timescale 1ns / 1ps
module murmur3_32_hash_check
   import m3h_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [WORD_W-1:0] csr_wdata,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,
   input  logic [CNT_W-1:0]  req_tuser,
   input  logic              req_tlast,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [WORD_W-1:0] rsp_tdata,
   output int                fail_count,
   output int                outstanding
);

   localparam int REPORT_MAX = 10;

   // Shadow of the block's state
   logic [WORD_W-1:0] seed_shadow;
   logic [WORD_W-1:0] run_hash;
   logic [WORD_W-1:0] byte_total;
   logic              msg_open;
   logic [WORD_W-1:0] hash_due[$];

   // Scratch for one transfer
   logic [WORD_W-1:0] tail_hash;
   logic [WORD_W-1:0] want_hash;
   logic [CNT_W-1:0]  tail_bytes;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int r);
      return (x << r) | (x >> (WORD_W - r));
   endfunction

   function automatic logic [WORD_W-1:0] scramble_word(input logic [WORD_W-1:0] k);
      logic [WORD_W-1:0] t;
      t = k * C1;
      t = rotl(t, 15);
      return t * C2;
   endfunction

   function automatic logic [WORD_W-1:0] fold_word(input logic [WORD_W-1:0] h,
                                                   input logic [WORD_W-1:0] k);
      logic [WORD_W-1:0] t;
      t = h ^ scramble_word(k);
      t = rotl(t, 13);
      return t * 32'd5 + BLOCK_ADD;
   endfunction

   function automatic logic [WORD_W-1:0] finalize(input logic [WORD_W-1:0] h);
      logic [WORD_W-1:0] t;
      t = h ^ (h >> 16);
      t = t * FMIX_M1;
      t = t ^ (t >> 13);
      t = t * FMIX_M2;
      return t ^ (t >> 16);
   endfunction

   // Mask keeping the low n bytes of a tail word
   function automatic logic [WORD_W-1:0] tail_mask(input logic [CNT_W-1:0] n);
      return (n == 0) ? '0 : ({WORD_W{1'b1}} >> (8 * (BYTES_FULL - n)));
   endfunction

   task automatic note_fail(input string what, input logic [WORD_W-1:0] exp_v,
                            input logic [WORD_W-1:0] act_v);
      fail_count++;
      if (fail_count <= REPORT_MAX)
         $display("[%0t] %s: expected %08h, got %08h", $realtime, what, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         seed_shadow = SEED_RESET;
         run_hash    = '0;
         byte_total  = '0;
         msg_open    = 1'b0;
         hash_due.delete();
      end else begin
         // result transfer: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (hash_due.size() == 0) begin
               note_fail("unexpected hash", '0, rsp_tdata);
            end else begin
               want_hash = hash_due.pop_front();
               if (rsp_tdata !== want_hash)
                  note_fail("hash_value", want_hash, rsp_tdata);
            end
         end

         if (csr_we)
            seed_shadow = csr_wdata;

         // word transfer: advance the running hash, predict on the final word
         if (req_tvalid && req_tready) begin
            if (!msg_open) begin
               run_hash   = seed_shadow;
               byte_total = '0;
               msg_open   = 1'b1;
            end
            if (!req_tlast) begin
               run_hash   = fold_word(run_hash, req_tdata);
               byte_total = byte_total + BYTES_FULL;
            end else begin
               tail_bytes = (req_tuser > BYTES_FULL) ? BYTES_FULL : req_tuser;
               tail_hash  = run_hash;
               if (tail_bytes == BYTES_FULL)
                  tail_hash = fold_word(tail_hash, req_tdata);
               else if (tail_bytes != 0)
                  tail_hash = tail_hash ^ scramble_word(req_tdata & tail_mask(tail_bytes));
               byte_total = byte_total + tail_bytes;
               tail_hash  = finalize(tail_hash ^ byte_total);
               hash_due.push_back(tail_hash);
               run_hash   = tail_hash;
               msg_open   = 1'b0;
            end
         end
      end
      outstanding = hash_due.size();
   end

endmodule

/* verif/murmur3_32_hash_test.sv */
// Testbench top for murmur3_32_hash: clock, reset, seed writes, word stimulus and verdict.
`timescale 1ns / 1ps
module murmur3_32_hash_test;
   import m3h_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 6;
   localparam int ITEM_TARGET  = 1800;
   localparam int PHASE_ITEMS  = 200;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 12;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_we = 1'b0;
   logic [WORD_W-1:0] csr_wdata = '0;
   logic              req_tvalid = 1'b0;
   logic [WORD_W-1:0] req_tdata = '0;
   logic [CNT_W-1:0]  req_tuser = '0;
   logic              req_tlast = 1'b0;
   logic              rsp_tready = 1'b0;
   logic              req_tready;
   logic              rsp_tvalid;
   logic [WORD_W-1:0] rsp_tdata;

   int fail_count;
   int outstanding;
   int items_sent = 0;
   int burst_left = 0;
   int gap_max = 0;
   int stall_pct = 0;
   bit hold_pending = 1'b0;

   murmur3_32_hash u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   murmur3_32_hash_check u_check (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // Watchdog
   initial begin
      int cycle_cnt = 0;
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("murmur3_32_hash: mismatch");
      $finish;
   end

   // Result side: random stalls, occasional stall runs, one long hold-off on request
   initial begin
      int hold_left = 0;
      int stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready = 1'b0;
         end else if (stall_pct != 0 && $urandom_range(99) < 3) begin
            stall_left = $urandom_range(25, 5);
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // One word transfer; called at a falling edge, returns at a falling edge
   task automatic send_item(input logic [WORD_W-1:0] word, input logic [CNT_W-1:0] nbytes,
                            input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(16, 1);
         gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tdata  = word;
      req_tuser  = nbytes;
      req_tlast  = last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   // Wait until every hash has come back and the sequencer has settled
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_seed(input logic [WORD_W-1:0] value);
      csr_wdata = value;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      int r;
      r = $urandom_range(99);
      if (r < 8)
         return '0;
      if (r < 16)
         return '1;
      return $urandom;
   endfunction

   // Random message: body words with noise in tuser, then a final word
   task automatic send_message();
      int body;
      logic [CNT_W-1:0] last_bytes;
      body = ($urandom_range(99) < 85) ? $urandom_range(7, 0) : $urandom_range(60, 20);
      last_bytes = ($urandom_range(99) < 80) ? CNT_W'($urandom_range(4, 0))
                                             : CNT_W'($urandom_range(7, 5));
      repeat (body) send_item(pick_word(), CNT_W'($urandom_range(7, 0)), 1'b0);
      send_item(pick_word(), last_bytes, 1'b1);
   endtask

   initial begin
      int phase;
      int phase_start;

      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // Directed: default seed, empty and partial tails, saturated counts
      gap_max   = 2;
      stall_pct = 20;
      send_item(32'hffffffff, 3'd0, 1'b1);
      send_item(32'hffffffff, BYTES_FULL, 1'b1);
      send_item(32'hdeadbeef, 3'd1, 1'b1);
      send_item(32'hdeadbeef, 3'd2, 1'b1);
      send_item(32'hdeadbeef, 3'd3, 1'b1);
      send_item(32'h00000000, 3'd5, 1'b1);
      send_item(32'h80000001, 3'd6, 1'b1);
      send_item(32'hffffffff, 3'd7, 1'b1);
      // multi-word message; tuser on body words is ignored
      send_item(32'h00000000, 3'd0, 1'b0);
      send_item(32'hffffffff, 3'd7, 1'b0);
      send_item(32'h80000001, 3'd3, 1'b1);
      // seed extremes, one written with a message open
      wait_idle();
      write_seed(32'h00000000);
      send_item(32'h12345678, 3'd2, 1'b0);
      wait_idle();
      write_seed(32'hffffffff);
      send_item(32'h9abcdef0, 3'd0, 1'b0);
      send_item(32'h0000a5a5, 3'd2, 1'b1);
      send_item(32'h00000000, BYTES_FULL, 1'b1);

      // Random phases, each with its own seed and flow-control mix
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         case (phase % 4)
            0: begin
               write_seed(32'h00000000);
               gap_max   = 0;
               stall_pct = 0;
            end
            1: begin
               write_seed(32'hffffffff);
               gap_max   = 3;
               stall_pct = 30;
            end
            2: begin
               write_seed(SEED_RESET);
               gap_max   = 1;
               stall_pct = 10;
               hold_pending = 1'b1;
            end
            default: begin
               write_seed($urandom);
               gap_max   = 10;
               stall_pct = 70;
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET)
            send_message();
         phase++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("murmur3_32_hash: match");
      else
         $display("murmur3_32_hash: mismatch");
      $finish;
   end

endmodule
